>>> hw/rtl/tcpm_pkg.sv
// Package for the torque/current plausibility monitor.
// Holds widths, the torque-to-current table, register indexes, FSM states and
// the controller/datapath command and status structs. No dependencies.
`default_nettype none

package tcpm_pkg;

    // Number of table points in use (2 .. 16)
    localparam int TABLE_POINTS = 16;

    localparam int TQ_W      = 8;    // torque percent
    localparam int MA_W      = 16;   // measured current, thresholds
    localparam int EXP_W     = 15;   // expected current
    localparam int CNT_W     = 8;    // debounce counters and tick registers
    localparam int REL_W     = 7;    // relative threshold percent
    localparam int DELTA_W   = 11;   // largest current step between table points
    localparam int SPAN_W    = 3;    // largest torque step between table points
    localparam int PROD_W    = DELTA_W + SPAN_W;
    localparam int DIVCNT_W  = $clog2(PROD_W + 1);
    localparam int RELP_W    = EXP_W + REL_W;
    localparam int D100_W    = MA_W + REL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 24;

    localparam logic [EXP_W-1:0] FULL_SCALE_MA = EXP_W'(25000);
    localparam logic [EXP_W-1:0] NEAR_ZERO_MA  = EXP_W'(100);
    localparam logic [TQ_W-1:0]  TQ_FULL       = TQ_W'(100);
    localparam logic [REL_W-1:0] PCT_SCALE     = REL_W'(100);

    localparam logic [TQ_W-1:0] TQ_AXIS [16] = '{
        8'd0,  8'd7,  8'd13, 8'd20, 8'd27, 8'd33, 8'd40, 8'd47,
        8'd53, 8'd60, 8'd67, 8'd73, 8'd80, 8'd87, 8'd93, 8'd100
    };
    localparam logic [EXP_W-1:0] MA_AXIS [16] = '{
        15'd0,     15'd1750,  15'd3250,  15'd5000,
        15'd6750,  15'd8250,  15'd10000, 15'd11750,
        15'd13250, 15'd15000, 15'd16750, 15'd18250,
        15'd20000, 15'd21750, 15'd23250, 15'd25000
    };

    // Register reset values
    localparam logic [MA_W-1:0]  RST_ABS_THR      = MA_W'(1000);
    localparam logic [REL_W-1:0] RST_REL_THR      = REL_W'(20);
    localparam logic [CNT_W-1:0] RST_MM_DEB       = CNT_W'(5);
    localparam logic [MA_W-1:0]  RST_CUTOFF_MA    = MA_W'(1000);
    localparam logic [CNT_W-1:0] RST_CUTOFF_TICKS = CNT_W'(10);
    localparam logic [MA_W-1:0]  RST_CREEP_MA     = MA_W'(500);
    localparam logic [CNT_W-1:0] RST_CREEP_DEB    = CNT_W'(5);
    localparam logic [MA_W-1:0]  RST_GRACE        = MA_W'(500);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ABS_THR,
        REG_REL_THR,
        REG_MM_DEB,
        REG_CUTOFF_MA,
        REG_CUTOFF_TICKS,
        REG_CREEP_MA,
        REG_CREEP_DEB,
        REG_GRACE
    } tcpm_reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV,
        ST_EXP,
        ST_CMP,
        ST_UPD
    } tcpm_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_start;
        logic exp_calc;
        logic cmp;
        logic update;
    } tcpm_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic plaus;
        logic creep;
        logic lamp;
    } tcpm_status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
        return (v == '0) ? CNT_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tcpm_div.sv
// Restoring divider for the interpolation quotient, one quotient bit a cycle.
// Depends on tcpm_pkg for widths.
`default_nettype none

module tcpm_div
    import tcpm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [SPAN_W-1:0] divisor,
    output logic      [PROD_W-1:0] quotient,
    output logic                   done
);

    logic [PROD_W-1:0]   quot_reg, quot_next;
    logic [SPAN_W-1:0]   rem_reg, rem_next;
    logic [SPAN_W-1:0]   dvs_reg;
    logic [DIVCNT_W-1:0] cnt_reg, cnt_next;
    logic [SPAN_W:0]     trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        trial     = {rem_reg, quot_reg[PROD_W-1]};
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = DIVCNT_W'(PROD_W);
        end else if (cnt_reg != '0) begin
            // shift in the next dividend bit, subtract where it fits
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = SPAN_W'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[SPAN_W-1:0];
                quot_next = {quot_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIVCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quot_reg;
    assign done     = (cnt_reg == '0);

endmodule

`default_nettype wire

>>> hw/rtl/tcpm_ctrl.sv
// Controller state machine for the plausibility monitor: sequences load,
// multiply, divide, compare and update. Depends on tcpm_pkg.
`default_nettype none

module tcpm_ctrl
    import tcpm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire tcpm_status_t status,
    output tcpm_cmd_t         cmd
);

    tcpm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                cmd.exp_calc = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                // hold until the output slot is free
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/tcpm_dpath.sv
// Datapath of the plausibility monitor: configuration registers, table lookup,
// interpolation, threshold compare, debounce counters and output register.
// Depends on tcpm_pkg and tcpm_div.
`default_nettype none

module tcpm_dpath
    import tcpm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire tcpm_cmd_t             cmd,
    output tcpm_status_t               status,
    input  wire logic                  in_torque_valid,
    input  wire logic [TQ_W-1:0]       in_torque,
    input  wire logic                  in_current_valid,
    input  wire logic [MA_W-1:0]       in_current_ma,
    input  wire logic                  in_brake_fault,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic                       out_plaus_fault,
    output logic                       out_creep_fault,
    output logic                       out_fault_lamp,
    output logic      [EXP_W-1:0]      out_exp_current,
    output logic                       out_mismatch
);

    // configuration
    logic [MA_W-1:0]  abs_thr_reg;
    logic [REL_W-1:0] rel_thr_reg;
    logic [CNT_W-1:0] mm_deb_reg;
    logic [MA_W-1:0]  cutoff_ma_reg;
    logic [CNT_W-1:0] cutoff_ticks_reg;
    logic [MA_W-1:0]  creep_ma_reg;
    logic [CNT_W-1:0] creep_deb_reg;

    // item and intermediate values
    logic              tv_reg, cv_reg, bf_reg;
    logic [TQ_W-1:0]   tq_reg;
    logic [MA_W-1:0]   cur_reg;
    logic [EXP_W-1:0]  base_reg;
    logic              interp_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [SPAN_W-1:0] span_reg, off_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [EXP_W-1:0]  expct_reg;
    logic [MA_W-1:0]   diff_reg;
    logic [RELP_W-1:0] relprod_reg;
    logic [D100_W-1:0] diff100_reg;
    logic              small_reg, over_abs_reg;

    // monitor state
    logic [CNT_W-1:0] mm_cnt_reg, mm_cnt_next;
    logic [CNT_W-1:0] cut_cnt_reg, cut_cnt_next;
    logic [CNT_W-1:0] creep_cnt_reg, creep_cnt_next;
    logic [MA_W-1:0]  grace_reg, grace_next;
    logic             plaus_reg, plaus_next;
    logic             creep_reg, creep_next;
    logic             lamp_reg, lamp_next;
    logic             upd_mm;

    // output slot
    logic             m_valid_reg;
    logic             o_plaus_reg, o_creep_reg, o_lamp_reg, o_mm_reg;
    logic [EXP_W-1:0] o_expct_reg;

    // table lookup
    logic [EXP_W-1:0]   seg_base;
    logic               seg_interp;
    logic [DELTA_W-1:0] seg_delta;
    logic [SPAN_W-1:0]  seg_span, seg_off;

    logic [PROD_W-1:0] quotient;
    logic              div_done;
    logic [EXP_W-1:0]  exp_sum;
    logic [MA_W-1:0]   exp_ext;

    always_comb begin
        logic found;
        found      = 1'b0;
        seg_base   = FULL_SCALE_MA;
        seg_interp = 1'b0;
        seg_delta  = '0;
        seg_span   = SPAN_W'(1);
        seg_off    = '0;
        if (in_torque == '0) begin
            seg_base = '0;
        end else if (in_torque < TQ_FULL) begin
            for (int k = 1; k < TABLE_POINTS; k++) begin
                if (!found && in_torque <= TQ_AXIS[k]) begin
                    found    = 1'b1;
                    seg_base = MA_AXIS[k-1];
                    // a flat or falling segment yields its lower point
                    seg_interp = (TQ_AXIS[k] > TQ_AXIS[k-1])
                              && (MA_AXIS[k] >= MA_AXIS[k-1]);
                    seg_delta  = DELTA_W'(MA_AXIS[k] - MA_AXIS[k-1]);
                    seg_span   = SPAN_W'(TQ_AXIS[k] - TQ_AXIS[k-1]);
                    seg_off    = SPAN_W'(in_torque - TQ_AXIS[k-1]);
                end
            end
        end
    end

    tcpm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign exp_sum = interp_reg ? base_reg + EXP_W'(quotient) : base_reg;
    assign exp_ext = MA_W'(exp_sum);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tv_reg     <= in_torque_valid;
            tq_reg     <= in_torque;
            cv_reg     <= in_current_valid;
            cur_reg    <= in_current_ma;
            bf_reg     <= in_brake_fault;
            base_reg   <= seg_base;
            interp_reg <= seg_interp;
            delta_reg  <= seg_delta;
            span_reg   <= seg_span;
            off_reg    <= seg_off;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(delta_reg) * PROD_W'(off_reg);
        end
        if (cmd.exp_calc) begin
            expct_reg <= exp_sum;
            diff_reg  <= (cur_reg >= exp_ext) ? cur_reg - exp_ext : exp_ext - cur_reg;
        end
        if (cmd.cmp) begin
            // diff > floor(e*r/100) holds exactly when 100*diff > e*r
            relprod_reg  <= RELP_W'(expct_reg) * RELP_W'(rel_thr_reg);
            diff100_reg  <= D100_W'(diff_reg) * D100_W'(PCT_SCALE);
            small_reg    <= (expct_reg < NEAR_ZERO_MA);
            over_abs_reg <= (diff_reg > abs_thr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_thr_reg      <= RST_ABS_THR;
            rel_thr_reg      <= RST_REL_THR;
            mm_deb_reg       <= RST_MM_DEB;
            cutoff_ma_reg    <= RST_CUTOFF_MA;
            cutoff_ticks_reg <= RST_CUTOFF_TICKS;
            creep_ma_reg     <= RST_CREEP_MA;
            creep_deb_reg    <= RST_CREEP_DEB;
        end else if (cfg_wr_en) begin
            case (tcpm_reg_idx_t'(cfg_wr_index))
                REG_ABS_THR:      abs_thr_reg      <= cfg_wr_data;
                REG_REL_THR:      rel_thr_reg      <= cfg_wr_data[REL_W-1:0];
                REG_MM_DEB:       mm_deb_reg       <= cfg_wr_data[CNT_W-1:0];
                REG_CUTOFF_MA:    cutoff_ma_reg    <= cfg_wr_data;
                REG_CUTOFF_TICKS: cutoff_ticks_reg <= cfg_wr_data[CNT_W-1:0];
                REG_CREEP_MA:     creep_ma_reg     <= cfg_wr_data;
                REG_CREEP_DEB:    creep_deb_reg    <= cfg_wr_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        mm_cnt_next    = mm_cnt_reg;
        cut_cnt_next   = cut_cnt_reg;
        creep_cnt_next = creep_cnt_reg;
        grace_next     = grace_reg;
        plaus_next     = plaus_reg;
        creep_next     = creep_reg;
        lamp_next      = lamp_reg;
        upd_mm         = 1'b0;
        if (cmd.update) begin
            if (grace_reg != '0) begin
                grace_next = grace_reg - MA_W'(1);
            end else begin
                if (!plaus_reg) begin
                    if (tv_reg && cv_reg) begin
                        upd_mm = over_abs_reg
                              && (small_reg || diff100_reg > D100_W'(relprod_reg));
                        if (upd_mm) begin
                            mm_cnt_next = sat_inc(mm_cnt_reg);
                            if (mm_cnt_next >= at_least_one(mm_deb_reg)) begin
                                plaus_next = 1'b1;
                            end
                        end else begin
                            mm_cnt_next = '0;
                        end
                    end
                    if (cv_reg && bf_reg && cur_reg > cutoff_ma_reg) begin
                        cut_cnt_next = sat_inc(cut_cnt_reg);
                        if (cut_cnt_next >= at_least_one(cutoff_ticks_reg)) begin
                            plaus_next = 1'b1;
                        end
                    end else begin
                        cut_cnt_next = '0;
                    end
                end
                if (!creep_reg && tv_reg && cv_reg) begin
                    if (tq_reg == '0 && cur_reg > creep_ma_reg) begin
                        creep_cnt_next = sat_inc(creep_cnt_reg);
                        if (creep_cnt_next >= at_least_one(creep_deb_reg)) begin
                            creep_next = 1'b1;
                        end
                    end else begin
                        creep_cnt_next = '0;
                    end
                end
                if (plaus_next || creep_next) begin
                    lamp_next = 1'b1;
                end
            end
        end else if (cfg_wr_en && tcpm_reg_idx_t'(cfg_wr_index) == REG_GRACE) begin
            // a write to REG_GRACE reloads the grace count, unless an update takes this cycle
            grace_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mm_cnt_reg    <= '0;
            cut_cnt_reg   <= '0;
            creep_cnt_reg <= '0;
            grace_reg     <= RST_GRACE;
            plaus_reg     <= 1'b0;
            creep_reg     <= 1'b0;
            lamp_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            mm_cnt_reg    <= mm_cnt_next;
            cut_cnt_reg   <= cut_cnt_next;
            creep_cnt_reg <= creep_cnt_next;
            grace_reg     <= grace_next;
            plaus_reg     <= plaus_next;
            creep_reg     <= creep_next;
            lamp_reg      <= lamp_next;
            if (cmd.update) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            o_plaus_reg <= plaus_next;
            o_creep_reg <= creep_next;
            o_lamp_reg  <= lamp_next;
            o_expct_reg <= expct_reg;
            o_mm_reg    <= upd_mm;
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || out_ready;
    assign status.plaus    = plaus_reg;
    assign status.creep    = creep_reg;
    assign status.lamp     = lamp_reg;

    assign out_valid       = m_valid_reg;
    assign out_plaus_fault = o_plaus_reg;
    assign out_creep_fault = o_creep_reg;
    assign out_fault_lamp  = o_lamp_reg;
    assign out_exp_current = o_expct_reg;
    assign out_mismatch    = o_mm_reg;

endmodule

`default_nettype wire

>>> hw/rtl/torque_current_plausibility_monitor.sv
// Torque versus current plausibility monitor, top level.
// Items are taken one at a time: a new input is accepted only after the
// last one has passed the 14-step divider loop of the interpolation and
// been written into the output register, where results wait.
// Reset (aresetn, synchronous, active low) loads register defaults, clears all
// counters and latched faults and reloads the grace count.
`default_nettype none

module torque_current_plausibility_monitor
    import tcpm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input item
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [0] torque_valid, [8:1] torque, [9] current_valid,
    // [25:10] current_ma, [26] brake_fault, [31:27] zero
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // result item
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] plaus_fault, [1] creep_fault, [2] fault_lamp,
    // [17:3] exp_current, [18] mismatch, [23:19] zero
    output logic      [M_DATA_W-1:0]   m_tdata,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    tcpm_cmd_t    cmd;
    tcpm_status_t dp_status;

    logic             o_plaus, o_creep, o_lamp, o_mm;
    logic [EXP_W-1:0] o_expct;

    // Sequence each transfer: load, multiply, divide, compare, update
    tcpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (dp_status),
        .cmd      (cmd)
    );

    // Unpack the input fields straight into the datapath
    tcpm_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (dp_status),
        .in_torque_valid  (s_tdata[0]),
        .in_torque        (s_tdata[8:1]),
        .in_current_valid (s_tdata[9]),
        .in_current_ma    (s_tdata[25:10]),
        .in_brake_fault   (s_tdata[26]),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_plaus_fault  (o_plaus),
        .out_creep_fault  (o_creep),
        .out_fault_lamp   (o_lamp),
        .out_exp_current  (o_expct),
        .out_mismatch     (o_mm)
    );

    // Pack the result fields, lowest field first, pad to whole bytes
    assign m_tdata = {5'b0, o_mm, o_expct, o_lamp, o_creep, o_plaus};

`ifndef SYNTH
    // The lamp is on whenever either fault is latched
    a_lamp_follows_faults: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (dp_status.plaus || dp_status.creep) |-> dp_status.lamp
    ) else $error("fault latched without lamp");

    // A latched plausibility fault only clears on reset
    a_plaus_sticky: assert property (
        @(posedge aclk) disable iff (!aresetn)
        dp_status.plaus |=> dp_status.plaus
    ) else $error("plausibility fault dropped");

    // A latched creep fault only clears on reset
    a_creep_sticky: assert property (
        @(posedge aclk) disable iff (!aresetn)
        dp_status.creep |=> dp_status.creep
    ) else $error("creep fault dropped");

    // One item at a time: no new transfer in the cycle after one is taken
    a_one_in_flight: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("input taken while busy");
`endif

endmodule

`default_nettype wire

>>> verif/tcpm_checker.sv
// Checker for the torque/current plausibility monitor.
// Watches the input, result and register-write ports, predicts every result
// with its own copy of the monitor state and compares; depends on tcpm_pkg.
`timescale 1ns / 1ps

module tcpm_checker
    import tcpm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int unsigned           fail_count,
    output int unsigned           pending
);

    localparam int unsigned FULL_MA      = 25000;
    localparam int unsigned LOW_CURRENT  = 100;
    localparam int unsigned PCT_DIVISOR  = 100;

    localparam int unsigned TORQUE_PTS [16] = '{
        0, 7, 13, 20, 27, 33, 40, 47, 53, 60, 67, 73, 80, 87, 93, 100
    };
    localparam int unsigned CURRENT_PTS [16] = '{
        0, 1750, 3250, 5000, 6750, 8250, 10000, 11750,
        13250, 15000, 16750, 18250, 20000, 21750, 23250, 25000
    };

    typedef struct packed {
        logic             torque_valid;
        logic [TQ_W-1:0]  torque;
        logic             current_valid;
        logic [MA_W-1:0]  current_ma;
        logic             brake_fault;
    } tick_t;

    // highest bits first, so plaus_fault lands in bit 0
    typedef struct packed {
        logic [4:0]       pad;
        logic             mismatch;
        logic [EXP_W-1:0] exp_current;
        logic             fault_lamp;
        logic             creep_fault;
        logic             plaus_fault;
    } status_t;

    // register copies
    logic [MA_W-1:0]  abs_thr, cutoff_ma, creep_ma, grace_reload;
    logic [REL_W-1:0] rel_pct;
    logic [CNT_W-1:0] mm_debounce, cutoff_limit, creep_limit;

    // monitor state
    logic [CNT_W-1:0] mm_run, cutoff_run, creep_run;
    logic [MA_W-1:0]  grace_left;
    logic             plaus_held, creep_held, lamp_held;

    status_t     predicted_status [$];
    int unsigned errors;
    int unsigned result_no;

    function automatic int unsigned interp_current(input logic [TQ_W-1:0] tq);
        int unsigned k, t0, t1, c0, c1;
        if (tq == '0)
            return 0;
        if (tq >= 100)
            return FULL_MA;
        for (k = 1; k < TABLE_POINTS; k++) begin
            if (tq <= TORQUE_PTS[k]) begin
                t0 = TORQUE_PTS[k-1];
                t1 = TORQUE_PTS[k];
                c0 = CURRENT_PTS[k-1];
                c1 = CURRENT_PTS[k];
                if (t1 <= t0 || c1 < c0)
                    return c0;
                return c0 + ((c1 - c0) * (tq - t0)) / (t1 - t0);
            end
        end
        return FULL_MA;
    endfunction

    function automatic bit beyond_limit(input int unsigned want_ma,
                                        input int unsigned seen_ma);
        int unsigned diff, lim;
        diff = (seen_ma > want_ma) ? seen_ma - want_ma : want_ma - seen_ma;
        if (want_ma < LOW_CURRENT)
            return diff > abs_thr;
        lim = (want_ma * rel_pct) / PCT_DIVISOR;
        if (lim < abs_thr)
            lim = abs_thr;
        return diff > lim;
    endfunction

    function automatic logic [CNT_W-1:0] floor_one(input logic [CNT_W-1:0] v);
        return (v == '0) ? CNT_W'(1) : v;
    endfunction

    task automatic restore_defaults();
        abs_thr        = 16'd1000;
        rel_pct        = 7'd20;
        mm_debounce    = 8'd5;
        cutoff_ma      = 16'd1000;
        cutoff_limit   = 8'd10;
        creep_ma       = 16'd500;
        creep_limit    = 8'd5;
        grace_reload   = 16'd500;
        grace_left     = grace_reload;
        mm_run         = '0;
        cutoff_run     = '0;
        creep_run      = '0;
        plaus_held     = 1'b0;
        creep_held     = 1'b0;
        lamp_held      = 1'b0;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        case (tcpm_reg_idx_t'(idx))
            REG_ABS_THR:      abs_thr        = value[MA_W-1:0];
            REG_REL_THR:      rel_pct        = value[REL_W-1:0];
            REG_MM_DEB:       mm_debounce    = value[CNT_W-1:0];
            REG_CUTOFF_MA:    cutoff_ma      = value[MA_W-1:0];
            REG_CUTOFF_TICKS: cutoff_limit   = value[CNT_W-1:0];
            REG_CREEP_MA:     creep_ma       = value[MA_W-1:0];
            REG_CREEP_DEB:    creep_limit    = value[CNT_W-1:0];
            REG_GRACE: begin
                grace_reload = value[MA_W-1:0];
                grace_left   = value[MA_W-1:0];
            end
            default: ;
        endcase
    endtask

    // Advance the monitor by one tick and return the status word it reports.
    task automatic predict_tick(input tick_t t, output status_t st);
        int unsigned want_ma;
        bit          off;
        want_ma = interp_current(t.torque);
        off     = 1'b0;
        if (grace_left != '0) begin
            grace_left = grace_left - 1'b1;
        end else begin
            if (!plaus_held) begin
                if (t.torque_valid && t.current_valid) begin
                    off = beyond_limit(want_ma, t.current_ma);
                    if (off) begin
                        if (mm_run != '1)
                            mm_run = mm_run + 1'b1;
                        if (mm_run >= floor_one(mm_debounce))
                            plaus_held = 1'b1;
                    end else begin
                        mm_run = '0;
                    end
                end
                if (t.current_valid && t.brake_fault && t.current_ma > cutoff_ma) begin
                    if (cutoff_run != '1)
                        cutoff_run = cutoff_run + 1'b1;
                    if (cutoff_run >= floor_one(cutoff_limit))
                        plaus_held = 1'b1;
                end else begin
                    cutoff_run = '0;
                end
            end
            if (!creep_held && t.torque_valid && t.current_valid) begin
                if (t.torque == '0 && t.current_ma > creep_ma) begin
                    if (creep_run != '1)
                        creep_run = creep_run + 1'b1;
                    if (creep_run >= floor_one(creep_limit))
                        creep_held = 1'b1;
                end else begin
                    creep_run = '0;
                end
            end
            if (plaus_held || creep_held)
                lamp_held = 1'b1;
        end
        st.plaus_fault = plaus_held;
        st.creep_fault = creep_held;
        st.fault_lamp  = lamp_held;
        st.exp_current = EXP_W'(want_ma);
        st.mismatch    = off;
        st.pad         = '0;
    endtask

    task automatic compare_field(input string fname, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            if (errors < 10)
                $display("%0t: result %0d, %s: expected %0d, got %0d",
                         $realtime, result_no, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        tick_t   tick;
        status_t want, got;
        if (!aresetn) begin
            restore_defaults();
            predicted_status.delete();
        end else begin
            if (cfg_wr_en)
                apply_write(cfg_wr_index, cfg_wr_data);
            // retire the result first: it belongs to an earlier tick
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (predicted_status.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result %0d arrived with none outstanding",
                                 $realtime, result_no);
                    errors++;
                end else begin
                    want = predicted_status.pop_front();
                    compare_field("plaus_fault", want.plaus_fault, got.plaus_fault);
                    compare_field("creep_fault", want.creep_fault, got.creep_fault);
                    compare_field("fault_lamp",  want.fault_lamp,  got.fault_lamp);
                    compare_field("exp_current", want.exp_current, got.exp_current);
                    compare_field("mismatch",    want.mismatch,    got.mismatch);
                    compare_field("padding",     want.pad,         got.pad);
                end
                result_no++;
            end
            if (s_tvalid && s_tready) begin
                tick.torque_valid  = s_tdata[0];
                tick.torque        = s_tdata[8:1];
                tick.current_valid = s_tdata[9];
                tick.current_ma    = s_tdata[25:10];
                tick.brake_fault   = s_tdata[26];
                predict_tick(tick, want);
                predicted_status.push_back(want);
            end
        end
        fail_count <= errors;
        pending    <= predicted_status.size();
    end

endmodule

>>> verif/tb.sv
// Top-level testbench for the torque/current plausibility monitor.
// Drives ticks and register writes into the block with bursty, stalled traffic;
// checking is done by tcpm_checker. Depends on tcpm_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import tcpm_pkg::*;

    // cycles with no transfer on either channel before the run is abandoned
    localparam int unsigned QUIET_LIMIT = 3000;
    // wait after the final drain before the verdict is printed
    localparam int unsigned SETTLE_CYCLES = 25;

    typedef enum logic [1:0] {
        RX_FREE,    // always ready
        RX_COMB,    // drop ready one cycle in four
        RX_COIN,    // ready on a coin toss
        RX_LONG     // mostly ready, with occasional long stalls
    } rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned quiet_cycles = 0;

    rx_mode_t    rx_mode = RX_FREE;
    logic [7:0]  rx_phase = '0;
    int unsigned rx_hold = 0;

    torque_current_plausibility_monitor dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    tcpm_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Result side: hold back tready on a pattern that changes each time rx_phase wraps.
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE: m_tready <= 1'b1;
                RX_COMB: m_tready <= (rx_phase[1:0] != 2'b11);
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                RX_LONG: begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        rx_hold <= $urandom_range(20, 60);
                end
                default: m_tready <= 1'b1;
            endcase
        end
        rx_phase <= rx_phase + 1'b1;
        if (rx_phase == '1)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
    end

    // Watchdog: count cycles in which neither channel makes a transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Pack one tick into the input word, lowest field first.
    function automatic logic [S_DATA_W-1:0] tick_word(input logic tv,
                                                      input logic [TQ_W-1:0] tq,
                                                      input logic cv,
                                                      input logic [MA_W-1:0] cur,
                                                      input logic bf);
        return {5'b0, bf, cur, cv, tq, tv};
    endfunction

    // Mostly valid ticks with a current near the nominal table value, so the
    // debounce counters rise and fall; the rest is noise and missing data.
    function automatic logic [S_DATA_W-1:0] random_tick();
        logic            tv, cv, bf;
        logic [TQ_W-1:0] tq;
        logic [MA_W-1:0] cur;
        int unsigned     pick, centre, spread;
        tv   = ($urandom_range(0, 9) != 0);
        cv   = ($urandom_range(0, 9) != 0);
        bf   = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 19);
        if (pick < 3)
            tq = '0;
        else if (pick < 15)
            tq = TQ_W'($urandom_range(1, 100));
        else
            tq = TQ_W'($urandom_range(0, 255));
        centre = ((tq > 100) ? 100 : tq) * 250;
        pick   = $urandom_range(0, 9);
        if (pick < 6) begin
            spread = $urandom_range(0, 8000);
            if ($urandom_range(0, 1) != 0)
                cur = MA_W'(centre + spread);
            else
                cur = (spread > centre) ? '0 : MA_W'(centre - spread);
        end else if (pick < 9) begin
            cur = MA_W'($urandom_range(0, 65535));
        end else begin
            cur = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        return tick_word(tv, tq, cv, cur, bf);
    endfunction

    // Present one tick and hold it until the transfer; tvalid stays high.
    task automatic offer_tick(input logic [S_DATA_W-1:0] word);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Stop sending and wait for every outstanding result to come back.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Caller lowers cfg_wr_en after the last write of a batch.
    task automatic write_reg(input tcpm_reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
    endtask

    function automatic logic [MA_W-1:0] current_setting();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return MA_W'($urandom_range(0, 65535));
            default: return MA_W'($urandom_range(100, 4000));
        endcase
    endfunction

    function automatic logic [REL_W-1:0] pct_setting();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return REL_W'(100);
            2:       return '1;
            default: return REL_W'($urandom_range(1, 99));
        endcase
    endfunction

    // Debounce setting with junk in the unused upper bits of the write.
    function automatic logic [CFG_DATA_W-1:0] debounce_setting(input bit latching);
        logic [CNT_W-1:0] v;
        v = latching ? CNT_W'($urandom_range(0, 4)) : CNT_W'($urandom_range(200, 255));
        return {8'($urandom_range(0, 255)), v};
    endfunction

    // Reprogram every register between phases. Long debounces keep the faults
    // open so the checks stay live; a latching phase uses short ones.
    task automatic load_phase_settings(input bit latching);
        logic [MA_W-1:0] grace;
        quiesce();
        grace = ($urandom_range(0, 2) == 0) ? '0 : MA_W'($urandom_range(1, 12));
        write_reg(REG_ABS_THR, current_setting());
        write_reg(REG_REL_THR, {9'($urandom_range(0, 511)), pct_setting()});
        write_reg(REG_MM_DEB, debounce_setting(latching));
        write_reg(REG_CUTOFF_MA, current_setting());
        write_reg(REG_CUTOFF_TICKS, debounce_setting(latching));
        write_reg(REG_CREEP_MA, current_setting());
        write_reg(REG_CREEP_DEB, debounce_setting(latching));
        write_reg(REG_GRACE, grace);
        cfg_wr_en <= 1'b0;
    endtask

    // Random ticks in bursts with random gaps; now and then drain completely.
    task automatic run_ticks(input int unsigned count);
        int unsigned sent, burst, pick;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                if (sent < count) begin
                    offer_tick(random_tick());
                    sent++;
                end
            end
            pick = $urandom_range(0, 39);
            if (pick == 0)
                quiesce();
            else if (pick > 16)
                pause_sender($urandom_range(1, 40));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: the grace count is still running, so only the
        // expected current is live.
        run_ticks(30);

        // Directed settings: default thresholds, debounces long enough that
        // nothing latches, two grace ticks.
        quiesce();
        write_reg(REG_ABS_THR, 16'd1000);
        write_reg(REG_REL_THR, 16'd20);
        write_reg(REG_MM_DEB, 16'd255);
        write_reg(REG_CUTOFF_MA, 16'd1000);
        write_reg(REG_CUTOFF_TICKS, 16'd255);
        write_reg(REG_CREEP_MA, 16'd500);
        write_reg(REG_CREEP_DEB, 16'd255);
        write_reg(REG_GRACE, 16'd2);
        cfg_wr_en <= 1'b0;

        // grace: gross deviation and brake fault must not count
        offer_tick(tick_word(1'b1, 8'd50, 1'b1, 16'hFFFF, 1'b1));
        offer_tick(tick_word(1'b1, 8'd50, 1'b1, 16'hFFFF, 1'b1));
        // zero torque: exact, then just over the absolute floor (also creep)
        offer_tick(tick_word(1'b1, 8'd0, 1'b1, 16'd0, 1'b0));
        offer_tick(tick_word(1'b1, 8'd0, 1'b1, 16'd1001, 1'b0));
        // smallest torque, and the first table point
        offer_tick(tick_word(1'b1, 8'd1, 1'b1, 16'd0, 1'b0));
        offer_tick(tick_word(1'b1, 8'd7, 1'b1, 16'd1750, 1'b0));
        // full torque: relative limit exceeded by one, then exactly on it
        offer_tick(tick_word(1'b1, 8'd100, 1'b1, 16'd30001, 1'b0));
        offer_tick(tick_word(1'b1, 8'd100, 1'b1, 16'd30000, 1'b0));
        // torque above 100 is full scale
        offer_tick(tick_word(1'b1, 8'd101, 1'b1, 16'd25000, 1'b0));
        offer_tick(tick_word(1'b1, 8'd255, 1'b1, 16'hFFFF, 1'b0));
        offer_tick(tick_word(1'b1, 8'd99, 1'b1, 16'd0, 1'b0));
        // torque missing: no comparison, but the cutoff still counts
        offer_tick(tick_word(1'b0, 8'd50, 1'b1, 16'hFFFF, 1'b1));
        // current missing: cutoff count clears
        offer_tick(tick_word(1'b1, 8'd50, 1'b0, 16'hFFFF, 1'b1));
        offer_tick(tick_word(1'b1, 8'd53, 1'b1, 16'd13250, 1'b1));
        // every input bit low, then every input bit high
        offer_tick(tick_word(1'b0, 8'd0, 1'b0, 16'd0, 1'b0));
        offer_tick(tick_word(1'b1, 8'hFF, 1'b1, 16'hFFFF, 1'b1));
        // interpolation between and on table points
        offer_tick(tick_word(1'b1, 8'd13, 1'b1, 16'd3250, 1'b0));
        offer_tick(tick_word(1'b1, 8'd93, 1'b1, 16'd23250, 1'b0));
        offer_tick(tick_word(1'b1, 8'd94, 1'b1, 16'd23500, 1'b0));

        // Random phases with the faults held open.
        repeat (8) begin
            load_phase_settings(1'b0);
            run_ticks(110);
        end

        // Last phase: short debounces so the faults latch, then keep going
        // to check that the latches hold and the checks stand down.
        load_phase_settings(1'b1);
        run_ticks(150);

        quiesce();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
